@@ rtl/sm83afu_pkg.sv @@
// Types and operation codes shared by the SM83 arithmetic and flag unit.
// Depends on nothing; used by sm83afu_exec and sm83_alu_flag_unit_core.
package sm83afu_pkg;

    typedef enum logic [4:0] {
        CMD_ADD   = 5'd0,
        CMD_ADC   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_SBC   = 5'd3,
        CMD_AND   = 5'd4,
        CMD_XOR   = 5'd5,
        CMD_OR    = 5'd6,
        CMD_CP    = 5'd7,
        CMD_RLCA  = 5'd8,
        CMD_RRCA  = 5'd9,
        CMD_RLA   = 5'd10,
        CMD_RRA   = 5'd11,
        CMD_DAA   = 5'd12,
        CMD_CPL   = 5'd13,
        CMD_SCF   = 5'd14,
        CMD_CCF   = 5'd15,
        CMD_INC   = 5'd16,
        CMD_DEC   = 5'd17,
        CMD_RLC   = 5'd18,
        CMD_RRC   = 5'd19,
        CMD_RL    = 5'd20,
        CMD_RR    = 5'd21,
        CMD_SLA   = 5'd22,
        CMD_SRA   = 5'd23,
        CMD_SWAP  = 5'd24,
        CMD_SRL   = 5'd25,
        CMD_BIT   = 5'd26,
        CMD_RES   = 5'd27,
        CMD_SET   = 5'd28,
        CMD_ADD16 = 5'd29,
        CMD_ADDSP = 5'd30
    } cmd_t;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [3:0]  NIBBLE_MAX = 4'h9;
    localparam logic [7:0]  BCD_MAX    = 8'h99;
    localparam logic [7:0]  CORR_LO    = 8'h06;
    localparam logic [7:0]  CORR_HI    = 8'h60;

    typedef struct packed {
        logic [4:0]  command;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
        logic [15:0] wide_a;
        logic [15:0] wide_b;
        logic [7:0]  offset;
    } item_t;

    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] wide_result;
        logic [3:0]  flags_out;
        logic        writes_back;
    } outcome_t;

endpackage

@@ rtl/sm83_alu_flag_unit_core.sv @@
// SM83 arithmetic and flag unit: input register, ALU datapath, result register.
// A transaction passes the input register, then the result register; throughput 1 per cycle while out_stall is low.
// A result waiting on out_stall does not block a new input transaction until
// both the input and result registers are full; the ALU path is one level.
// Reset (rst_n low, asynchronous) empties both registers; payload is not cleared.
// Depends on sm83afu_pkg and sm83afu_exec.
module sm83_alu_flag_unit_core
    import sm83afu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [4:0]        command,
    input  logic [7:0]        acc,
    input  logic [7:0]        operand,
    input  logic [2:0]        bit_index,
    input  logic [3:0]        flags_in,
    input  logic [15:0]       wide_a,
    input  logic [15:0]       wide_b,
    input  logic signed [7:0] offset,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        result,
    output logic [15:0]       wide_result,
    output logic [3:0]        flags_out,
    output logic              writes_back
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    item_t    s1_item_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    outcome_t out_item_reg;
    outcome_t exec_out;
    logic     out_free;
    logic     in_take;
    logic     s1_move;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !out_free);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the input register while the result register is blocked
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.command   <= command;
            s1_item_reg.acc       <= acc;
            s1_item_reg.operand   <= operand;
            s1_item_reg.bit_index <= bit_index;
            s1_item_reg.flags_in  <= flags_in;
            s1_item_reg.wide_a    <= wide_a;
            s1_item_reg.wide_b    <= wide_b;
            s1_item_reg.offset    <= offset;
        end
    end

    sm83afu_exec u_exec
    (
        .item    (s1_item_reg),
        .outcome (exec_out)
    );

    // advance the result register only when the previous transaction has left
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_item_reg <= exec_out;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result      = out_item_reg.result;
    assign wide_result = out_item_reg.wide_result;
    assign flags_out   = out_item_reg.flags_out;
    assign writes_back = out_item_reg.writes_back;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled without both registers full");

    a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("result register not filled after move");

    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("input register not filled after transaction");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result register kept a delivered transaction");

endmodule

@@ rtl/sm83afu_exec.sv @@
// Combinational datapath of the SM83 arithmetic and flag unit: one item in,
// one outcome out. Depends on sm83afu_pkg.
module sm83afu_exec
    import sm83afu_pkg::*;
(
    input  item_t    item,
    output outcome_t outcome
);

    logic [7:0]  a;
    logic [7:0]  v;
    logic [3:0]  f;
    logic        cin;
    logic        carry_use;
    logic [8:0]  sum9;
    logic [4:0]  half_sum;
    logic        borrow_use;
    logic [8:0]  diff9;
    logic [4:0]  half_diff;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_corr;
    logic [7:0]  daa_res;
    logic [16:0] sum17;
    logic [12:0] half12;
    logic [15:0] off_ext;
    logic [8:0]  sp_lo;
    logic [4:0]  sp_half;
    logic [7:0]  bit_mask;
    logic [7:0]  res;
    logic [15:0] wide;
    logic [3:0]  fo;
    logic        wr;

    assign a   = item.acc;
    assign v   = item.operand;
    assign f   = item.flags_in;
    assign cin = item.flags_in[FLAG_C];

    assign carry_use  = (cmd_t'(item.command) == CMD_ADC) ? cin : 1'b0;
    assign borrow_use = (cmd_t'(item.command) == CMD_SBC) ? cin : 1'b0;

    assign sum9      = {1'b0, a} + {1'b0, v} + {8'd0, carry_use};
    assign half_sum  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, carry_use};
    assign diff9     = {1'b0, a} - {1'b0, v} - {8'd0, borrow_use};
    assign half_diff = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, borrow_use};

    assign daa_lo   = f[FLAG_H] || (!f[FLAG_N] && (a[3:0] > NIBBLE_MAX));
    assign daa_hi   = cin || (!f[FLAG_N] && (a > BCD_MAX));
    assign daa_corr = (daa_lo ? CORR_LO : 8'h00) | (daa_hi ? CORR_HI : 8'h00);
    assign daa_res  = f[FLAG_N] ? (a - daa_corr) : (a + daa_corr);

    assign sum17   = {1'b0, item.wide_a} + {1'b0, item.wide_b};
    assign half12  = {1'b0, item.wide_a[11:0]} + {1'b0, item.wide_b[11:0]};
    assign off_ext = {{8{item.offset[7]}}, item.offset};
    assign sp_lo   = {1'b0, item.wide_a[7:0]} + {1'b0, item.offset};
    assign sp_half = {1'b0, item.wide_a[3:0]} + {1'b0, item.offset[3:0]};

    assign bit_mask = 8'd1 << item.bit_index;

    always_comb
    begin
        res  = a;
        wide = 16'd0;
        fo   = f;
        wr   = 1'b1;
        case (cmd_t'(item.command))
            CMD_ADD, CMD_ADC:
            begin
                res = sum9[7:0];
                fo  = {(sum9[7:0] == 8'd0), 1'b0, half_sum[4], sum9[8]};
            end
            CMD_SUB, CMD_SBC:
            begin
                res = diff9[7:0];
                fo  = {(diff9[7:0] == 8'd0), 1'b1, half_diff[4], diff9[8]};
            end
            CMD_CP:
            begin
                wr = 1'b0;
                fo = {(diff9[7:0] == 8'd0), 1'b1, half_diff[4], diff9[8]};
            end
            CMD_AND:
            begin
                res = a & v;
                fo  = {((a & v) == 8'd0), 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR:
            begin
                res = a ^ v;
                fo  = {((a ^ v) == 8'd0), 3'b000};
            end
            CMD_OR:
            begin
                res = a | v;
                fo  = {((a | v) == 8'd0), 3'b000};
            end
            CMD_RLCA:
            begin
                res = {a[6:0], a[7]};
                fo  = {3'b000, a[7]};
            end
            CMD_RRCA:
            begin
                res = {a[0], a[7:1]};
                fo  = {3'b000, a[0]};
            end
            CMD_RLA:
            begin
                res = {a[6:0], cin};
                fo  = {3'b000, a[7]};
            end
            CMD_RRA:
            begin
                res = {cin, a[7:1]};
                fo  = {3'b000, a[0]};
            end
            CMD_DAA:
            begin
                res = daa_res;
                fo  = {(daa_res == 8'd0), f[FLAG_N], 1'b0, daa_hi};
            end
            CMD_CPL:
            begin
                res = ~a;
                fo  = f | 4'b0110;
            end
            CMD_SCF:
            begin
                wr = 1'b0;
                fo = {f[FLAG_Z], 3'b001};
            end
            CMD_CCF:
            begin
                wr = 1'b0;
                fo = {f[FLAG_Z], 2'b00, ~cin};
            end
            CMD_INC:
            begin
                res = v + 8'd1;
                fo  = {(v == 8'hFF), 1'b0, (v[3:0] == 4'hF), cin};
            end
            CMD_DEC:
            begin
                res = v - 8'd1;
                fo  = {(v == 8'h01), 1'b1, (v[3:0] == 4'h0), cin};
            end
            CMD_RLC:
            begin
                res = {v[6:0], v[7]};
                fo  = {(v == 8'd0), 2'b00, v[7]};
            end
            CMD_RRC:
            begin
                res = {v[0], v[7:1]};
                fo  = {(v == 8'd0), 2'b00, v[0]};
            end
            CMD_RL:
            begin
                res = {v[6:0], cin};
                fo  = {({v[6:0], cin} == 8'd0), 2'b00, v[7]};
            end
            CMD_RR:
            begin
                res = {cin, v[7:1]};
                fo  = {({cin, v[7:1]} == 8'd0), 2'b00, v[0]};
            end
            CMD_SLA:
            begin
                res = {v[6:0], 1'b0};
                fo  = {(v[6:0] == 7'd0), 2'b00, v[7]};
            end
            CMD_SRA:
            begin
                res = {v[7], v[7:1]};
                fo  = {(v[7:1] == 7'd0), 2'b00, v[0]};
            end
            CMD_SWAP:
            begin
                res = {v[3:0], v[7:4]};
                fo  = {(v == 8'd0), 3'b000};
            end
            CMD_SRL:
            begin
                res = {1'b0, v[7:1]};
                fo  = {(v[7:1] == 7'd0), 2'b00, v[0]};
            end
            CMD_BIT:
            begin
                res = v;
                wr  = 1'b0;
                fo  = {((v & bit_mask) == 8'd0), 1'b0, 1'b1, cin};
            end
            CMD_RES:
            begin
                res = v & ~bit_mask;
            end
            CMD_SET:
            begin
                res = v | bit_mask;
            end
            CMD_ADD16:
            begin
                res  = 8'd0;
                wide = sum17[15:0];
                fo   = {f[FLAG_Z], 1'b0, half12[12], sum17[16]};
            end
            CMD_ADDSP:
            begin
                res  = 8'd0;
                wide = item.wide_a + off_ext;
                fo   = {2'b00, sp_half[4], sp_lo[8]};
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
    end

    assign outcome.result      = res;
    assign outcome.wide_result = wide;
    assign outcome.flags_out   = fo;
    assign outcome.writes_back = wr;

endmodule

@@ tb/sv/tb.sv @@
// Testbench for sm83_alu_flag_unit_core: a directed table, then random transactions,
// each result checked field by field against table values or an in-bench ALU and flag predictor.
// Depends on sm83afu_pkg and the unit's RTL.
module tb;
    import sm83afu_pkg::*;

    localparam logic [4:0]  CMD_UNUSED   = 5'd31;
    localparam int          RANDOM_ITEMS = 1516;
    localparam int          QUIET_ITEMS  = 200;
    localparam int          HOLD_AT      = 400;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_PRINTS   = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct {
        item_t    it;
        bit       typed;
        outcome_t want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [4:0]        command;
    logic [7:0]        acc;
    logic [7:0]        operand;
    logic [2:0]        bit_index;
    logic [3:0]        flags_in;
    logic [15:0]       wide_a;
    logic [15:0]       wide_b;
    logic signed [7:0] offset;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        result;
    logic [15:0]       wide_result;
    logic [3:0]        flags_out;
    logic              writes_back;

    stim_row_t   stim_rows[$];
    outcome_t    pending_outcomes[$];
    int unsigned cycles       = 0;
    int          n_errors     = 0;
    int          n_accepted   = 0;
    int          n_in_stalled = 0;
    logic [31:0] cmd_seen     = '0;
    bit          quiet        = 1'b0;
    bit          holding      = 1'b0;
    bit          held_once    = 1'b0;

    sm83_alu_flag_unit_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .acc         (acc),
        .operand     (operand),
        .bit_index   (bit_index),
        .flags_in    (flags_in),
        .wide_a      (wide_a),
        .wide_b      (wide_b),
        .offset      (offset),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .wide_result (wide_result),
        .flags_out   (flags_out),
        .writes_back (writes_back)
    );

    always #5 clk = ~clk;

    function automatic outcome_t alu_outcome(input item_t it);
        outcome_t    o;
        logic [7:0]  a;
        logic [7:0]  v;
        logic [7:0]  corr;
        logic [8:0]  sum9;
        logic [4:0]  nib;
        logic [12:0] sum13;
        logic [16:0] sum17;
        logic [15:0] ext;
        logic        cin;
        logic        cy;
        logic        neg;
        logic        setc;
        a = it.acc;
        v = it.operand;
        cin = it.flags_in[FLAG_C];
        o.result = a;
        o.wide_result = 16'h0000;
        o.flags_out = it.flags_in;
        o.writes_back = 1'b1;
        case (it.command)
            CMD_ADD, CMD_ADC:
            begin
                cy = (it.command == CMD_ADC) ? cin : 1'b0;
                sum9 = {1'b0, a} + {1'b0, v} + {8'h00, cy};
                nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cy};
                o.result = sum9[7:0];
                o.flags_out = {sum9[7:0] == 8'h00, 1'b0, nib[4], sum9[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                cy = (it.command == CMD_SBC) ? cin : 1'b0;
                sum9 = {1'b0, a} - {1'b0, v} - {8'h00, cy};
                nib = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, cy};
                o.result = sum9[7:0];
                o.flags_out = {sum9[7:0] == 8'h00, 1'b1, nib[4], sum9[8]};
                if (it.command == CMD_CP)
                begin
                    o.result = a;
                    o.writes_back = 1'b0;
                end
            end
            CMD_AND:
            begin
                o.result = a & v;
                o.flags_out = {o.result == 8'h00, 3'b010};
            end
            CMD_XOR:
            begin
                o.result = a ^ v;
                o.flags_out = {o.result == 8'h00, 3'b000};
            end
            CMD_OR:
            begin
                o.result = a | v;
                o.flags_out = {o.result == 8'h00, 3'b000};
            end
            CMD_RLCA:
            begin
                o.result = {a[6:0], a[7]};
                o.flags_out = {3'b000, a[7]};
            end
            CMD_RRCA:
            begin
                o.result = {a[0], a[7:1]};
                o.flags_out = {3'b000, a[0]};
            end
            CMD_RLA:
            begin
                o.result = {a[6:0], cin};
                o.flags_out = {3'b000, a[7]};
            end
            CMD_RRA:
            begin
                o.result = {cin, a[7:1]};
                o.flags_out = {3'b000, a[0]};
            end
            CMD_DAA:
            begin
                neg = it.flags_in[FLAG_N];
                corr = 8'h00;
                setc = 1'b0;
                if (it.flags_in[FLAG_H] || (!neg && a[3:0] > NIBBLE_MAX))
                    corr = corr | CORR_LO;
                if (cin || (!neg && a > BCD_MAX))
                begin
                    corr = corr | CORR_HI;
                    setc = 1'b1;
                end
                o.result = neg ? a - corr : a + corr;
                o.flags_out = {o.result == 8'h00, neg, 1'b0, setc};
            end
            CMD_CPL:
            begin
                o.result = ~a;
                o.flags_out[FLAG_N] = 1'b1;
                o.flags_out[FLAG_H] = 1'b1;
            end
            CMD_SCF:
            begin
                o.writes_back = 1'b0;
                o.flags_out = {it.flags_in[FLAG_Z], 3'b001};
            end
            CMD_CCF:
            begin
                o.writes_back = 1'b0;
                o.flags_out = {it.flags_in[FLAG_Z], 2'b00, ~cin};
            end
            CMD_INC:
            begin
                o.result = v + 8'h01;
                o.flags_out = {o.result == 8'h00, 1'b0, v[3:0] == 4'hF, cin};
            end
            CMD_DEC:
            begin
                o.result = v - 8'h01;
                o.flags_out = {o.result == 8'h00, 1'b1, v[3:0] == 4'h0, cin};
            end
            CMD_RLC:
            begin
                o.result = {v[6:0], v[7]};
                o.flags_out = {o.result == 8'h00, 2'b00, v[7]};
            end
            CMD_RRC:
            begin
                o.result = {v[0], v[7:1]};
                o.flags_out = {o.result == 8'h00, 2'b00, v[0]};
            end
            CMD_RL:
            begin
                o.result = {v[6:0], cin};
                o.flags_out = {o.result == 8'h00, 2'b00, v[7]};
            end
            CMD_RR:
            begin
                o.result = {cin, v[7:1]};
                o.flags_out = {o.result == 8'h00, 2'b00, v[0]};
            end
            CMD_SLA:
            begin
                o.result = {v[6:0], 1'b0};
                o.flags_out = {o.result == 8'h00, 2'b00, v[7]};
            end
            CMD_SRA:
            begin
                o.result = {v[7], v[7:1]};
                o.flags_out = {o.result == 8'h00, 2'b00, v[0]};
            end
            CMD_SWAP:
            begin
                o.result = {v[3:0], v[7:4]};
                o.flags_out = {o.result == 8'h00, 3'b000};
            end
            CMD_SRL:
            begin
                o.result = {1'b0, v[7:1]};
                o.flags_out = {o.result == 8'h00, 2'b00, v[0]};
            end
            CMD_BIT:
            begin
                o.result = v;
                o.writes_back = 1'b0;
                o.flags_out = {~v[it.bit_index], 2'b01, cin};
            end
            CMD_RES:
                o.result = v & ~(8'h01 << it.bit_index);
            CMD_SET:
                o.result = v | (8'h01 << it.bit_index);
            CMD_ADD16:
            begin
                sum17 = {1'b0, it.wide_a} + {1'b0, it.wide_b};
                sum13 = {1'b0, it.wide_a[11:0]} + {1'b0, it.wide_b[11:0]};
                o.result = 8'h00;
                o.wide_result = sum17[15:0];
                o.flags_out = {it.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[16]};
            end
            CMD_ADDSP:
            begin
                ext = {{8{it.offset[7]}}, it.offset};
                sum9 = {1'b0, it.wide_a[7:0]} + {1'b0, it.offset};
                nib = {1'b0, it.wide_a[3:0]} + {1'b0, it.offset[3:0]};
                o.result = 8'h00;
                o.wide_result = it.wide_a + ext;
                o.flags_out = {2'b00, nib[4], sum9[8]};
            end
            default:
                o.writes_back = 1'b0;
        endcase
        return o;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(input logic [4:0] cmd, input logic [7:0] a, input logic [7:0] v,
                           input logic [2:0] bi, input logic [3:0] f,
                           input logic [15:0] wa, input logic [15:0] wb,
                           input logic [7:0] off, input bit typed, input logic [7:0] res,
                           input logic [15:0] wres, input logic [3:0] fo, input logic wr);
        stim_row_t row;
        row.it = {cmd, a, v, bi, f, wa, wb, off};
        row.typed = typed;
        row.want = {res, wres, fo, wr};
        stim_rows.push_back(row);
    endtask

    task automatic report(input string field, input int unsigned got, input int unsigned want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got 'h%0h, wanted 'h%0h",
                     cycles, field, got, want);
    endtask

    task automatic offer(input item_t it, input bit typed, input outcome_t want);
        @(negedge clk);
        in_valid  <= 1'b1;
        command   <= it.command;
        acc       <= it.acc;
        operand   <= it.operand;
        bit_index <= it.bit_index;
        flags_in  <= it.flags_in;
        wide_a    <= it.wide_a;
        wide_b    <= it.wide_b;
        offset    <= it.offset;
        do
            @(posedge clk);
        while (in_stall);
        pending_outcomes.push_back(typed ? want : alu_outcome(it));
        cmd_seen[it.command] = 1'b1;
        n_accepted++;
        if (!quiet && !holding && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        item_t    it;
        outcome_t unused;
        int       n;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = '0;
        acc       = '0;
        operand   = '0;
        bit_index = '0;
        flags_in  = '0;
        wide_a    = '0;
        wide_b    = '0;
        offset    = '0;
        unused    = '0;

        add_row(CMD_ADD,    'h00, 'h00, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'h00, 'h0000, 'h8, 1);
        add_row(CMD_ADD,    'hFF, 'h01, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'h00, 'h0000, 'hB, 1);
        add_row(CMD_ADC,    'h0F, 'h00, 0, 'h1, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SUB,    'h00, 'h01, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'hFF, 'h0000, 'h7, 1);
        add_row(CMD_SBC,    'h10, 'h0F, 0, 'h1, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_AND,    'hFF, 'hFF, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'hFF, 'h0000, 'h2, 1);
        add_row(CMD_XOR,    'hFF, 'hFF, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'h00, 'h0000, 'h8, 1);
        add_row(CMD_OR,     'h00, 'h00, 0, 'hF, 'h0000, 'h0000, 'h00, 1, 'h00, 'h0000, 'h8, 1);
        add_row(CMD_CP,     'h42, 'h42, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'h42, 'h0000, 'hC, 0);
        add_row(CMD_RLCA,   'h80, 'h00, 0, 'hF, 'h0000, 'h0000, 'h00, 1, 'h01, 'h0000, 'h1, 1);
        add_row(CMD_RRCA,   'h01, 'h00, 0, 'h8, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_RLA,    'h80, 'h00, 0, 'h1, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_RRA,    'h01, 'h00, 0, 'h0, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_DAA,    'h9A, 'h00, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'h00, 'h0000, 'h9, 1);
        add_row(CMD_DAA,    'h00, 'h00, 0, 'h7, 'h0000, 'h0000, 'h00, 1, 'h9A, 'h0000, 'h5, 1);
        add_row(CMD_CPL,    'h00, 'h00, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'hFF, 'h0000, 'h6, 1);
        add_row(CMD_SCF,    'h5A, 'h00, 0, 'hF, 'h0000, 'h0000, 'h00, 1, 'h5A, 'h0000, 'h9, 0);
        add_row(CMD_CCF,    'h5A, 'h00, 0, 'h1, 'h0000, 'h0000, 'h00, 1, 'h5A, 'h0000, 'h0, 0);
        add_row(CMD_INC,    'h00, 'hFF, 0, 'h1, 'h0000, 'h0000, 'h00, 1, 'h00, 'h0000, 'hB, 1);
        add_row(CMD_DEC,    'h00, 'h01, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'h00, 'h0000, 'hC, 1);
        add_row(CMD_RLC,    'h00, 'h80, 0, 'h0, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_RRC,    'h00, 'h01, 0, 'h0, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_RL,     'h00, 'hFF, 0, 'h0, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_RR,     'h00, 'h00, 0, 'h1, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SLA,    'h00, 'h80, 0, 'h0, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SRA,    'h00, 'h81, 0, 'h0, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SWAP,   'h00, 'hF0, 0, 'h0, 'h0000, 'h0000, 'h00, 1, 'h0F, 'h0000, 'h0, 1);
        add_row(CMD_SRL,    'h00, 'h01, 0, 'h0, 'h0000, 'h0000, 'h00, 0, 0, 0, 0, 0);
        add_row(CMD_BIT,    'h00, 'h80, 7, 'h0, 'h0000, 'h0000, 'h00, 1, 'h80, 'h0000, 'h2, 0);
        add_row(CMD_RES,    'h00, 'hFF, 0, 'h5, 'h0000, 'h0000, 'h00, 1, 'hFE, 'h0000, 'h5, 1);
        add_row(CMD_SET,    'h00, 'h00, 7, 'hA, 'h0000, 'h0000, 'h00, 1, 'h80, 'h0000, 'hA, 1);
        add_row(CMD_ADD16,  'h00, 'h00, 0, 'h8, 'hFFFF, 'h0001, 'h00, 1, 'h00, 'h0000, 'hB, 1);
        add_row(CMD_ADDSP,  'h00, 'h00, 0, 'hF, 'hFFFF, 'h0000, 'hFF, 1, 'h00, 'hFFFE, 'h3, 1);
        add_row(CMD_UNUSED, 'h5A, 'h00, 0, 'hA, 'h0000, 'h0000, 'h00, 1, 'h5A, 'h0000, 'hA, 0);

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (stim_rows[i])
            offer(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet        = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            it.command   = 5'($urandom_range(0, 31));
            it.acc       = pick_byte();
            it.operand   = pick_byte();
            it.bit_index = 3'($urandom_range(0, 7));
            it.flags_in  = 4'($urandom_range(0, 15));
            it.wide_a    = pick_word();
            it.wide_b    = pick_word();
            it.offset    = pick_byte();
            offer(it, 1'b0, unused);
        end

        @(negedge clk) in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions (%0d table rows, %0d random) over %0d command codes",
                 n_accepted, stim_rows.size(), RANDOM_ITEMS, $countones(cmd_seen));
        $display("result side held off %0d cycles once; input stalled on %0d cycles",
                 HOLD_CYCLES, n_in_stalled);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin : receiver
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_once && n_accepted >= HOLD_AT)
            begin
                held_once = 1'b1;
                holding   = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                holding   = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        outcome_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        if (rst_n && in_valid && in_stall)
            n_in_stalled++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
                report("result with nothing pending", result, 0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (result !== want.result)
                    report("result", result, want.result);
                if (wide_result !== want.wide_result)
                    report("wide_result", wide_result, want.wide_result);
                if (flags_out !== want.flags_out)
                    report("flags_out", flags_out, want.flags_out);
                if (writes_back !== want.writes_back)
                    report("writes_back", writes_back, want.writes_back);
            end
        end
    end

endmodule
